// ===== rtl/core/ssbg_pkg.sv =====
// Shared types, constants and table functions for the Sobol bitstream generator.
package ssbg_pkg;

  localparam int SEED_CNT = 6;

  localparam logic [2:0] CFG_POINT_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_DIMENSION     = 3'd1;
  localparam logic [2:0] CFG_CUSTOM_DEGREE = 3'd2;
  localparam logic [2:0] CFG_CUSTOM_COEFFS = 3'd3;
  localparam logic [2:0] CFG_CUSTOM_INIT   = 3'd4;

  localparam logic [5:0]  RST_POINT_WIDTH   = 6'd16;
  localparam logic [4:0]  RST_DIMENSION     = 5'd1;
  localparam logic [2:0]  RST_CUSTOM_DEGREE = 3'd1;
  localparam logic [4:0]  RST_CUSTOM_COEFFS = 5'd0;
  localparam logic [20:0] RST_CUSTOM_INIT   = 21'd33867;

  typedef enum logic [1:0] {
    ST_BUILD,
    ST_SETTLE,
    ST_RUN,
    ST_JUMP
  } state_t;

  typedef struct packed {
    logic [2:0]                 deg;
    logic [4:0]                 coef;
    logic [SEED_CNT-1:0][5:0]   seed;   // seed[0] is m1
  } row_t;

  function automatic row_t mk_row(input logic [2:0] d, input logic [4:0] c,
                                  input logic [35:0] s);
    row_t r;
    r.deg  = d;
    r.coef = c;
    r.seed = s;
    return r;
  endfunction

  // rows for dimensions 2..19; seeds listed m6 down to m1
  function automatic row_t row_lookup(input logic [4:0] idx);
    row_t r;
    unique case (idx)
      5'd0:  r = mk_row(3'd1, 5'd0,  {6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1});
      5'd1:  r = mk_row(3'd2, 5'd1,  {6'd0, 6'd0, 6'd0, 6'd0, 6'd3, 6'd1});
      5'd2:  r = mk_row(3'd3, 5'd1,  {6'd0, 6'd0, 6'd0, 6'd1, 6'd3, 6'd1});
      5'd3:  r = mk_row(3'd3, 5'd2,  {6'd0, 6'd0, 6'd0, 6'd1, 6'd1, 6'd1});
      5'd4:  r = mk_row(3'd4, 5'd1,  {6'd0, 6'd0, 6'd3, 6'd3, 6'd1, 6'd1});
      5'd5:  r = mk_row(3'd4, 5'd4,  {6'd0, 6'd0, 6'd13, 6'd5, 6'd3, 6'd1});
      5'd6:  r = mk_row(3'd5, 5'd2,  {6'd0, 6'd17, 6'd5, 6'd5, 6'd1, 6'd1});
      5'd7:  r = mk_row(3'd5, 5'd4,  {6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd8:  r = mk_row(3'd5, 5'd7,  {6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd9:  r = mk_row(3'd5, 5'd11, {6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd10: r = mk_row(3'd5, 5'd13, {6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd11: r = mk_row(3'd5, 5'd14, {6'd0, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd12: r = mk_row(3'd6, 5'd1,  {6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd13: r = mk_row(3'd6, 5'd13, {6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd14: r = mk_row(3'd6, 5'd16, {6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd15: r = mk_row(3'd6, 5'd19, {6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      5'd16: r = mk_row(3'd6, 5'd22, {6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
      default: r = mk_row(3'd6, 5'd25, {6'd1, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1});
    endcase
    return r;
  endfunction

  // packed m1..m6, m_i in i bits from bit i(i-1)/2, forced odd
  function automatic logic [SEED_CNT-1:0][5:0] unpack_seeds(input logic [20:0] v);
    logic [SEED_CNT-1:0][5:0] s;
    s[0] = {5'd0, v[0]} | 6'd1;
    s[1] = {4'd0, v[2:1]} | 6'd1;
    s[2] = {3'd0, v[5:3]} | 6'd1;
    s[3] = {2'd0, v[9:6]} | 6'd1;
    s[4] = {1'd0, v[14:10]} | 6'd1;
    s[5] = v[20:15] | 6'd1;
    return s;
  endfunction

  // index of the lowest zero bit, capped at 31
  function automatic logic [4:0] lowest_zero(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd31;
    for (int i = 30; i >= 0; i--) begin
      if (!v[i]) n = 5'(i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/ssbg_ram.sv =====
// Generic single-port RAM with registered read.
module ssbg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/sobol_stochastic_bitstream_gen.sv =====
// Sobol point generator with stochastic-computing comparator output.
// Advance: accepted one per cycle while the output is not stalled; result registered, valid the cycle after accept.
// Jump: occupies the block while the point is rebuilt from the Gray code of the jump index, emits no result.
// Direction vectors are rebuilt after reset and after every configuration write to
// indices 0..4, one RAM entry per cycle; no item is taken meanwhile.
// Reset (synchronous, active low) loads register defaults and zeroes position and point.
module sobol_stochastic_bitstream_gen #(
  parameter int MAX_POINT_WIDTH  = 32,
  parameter int TABLE_DIMENSIONS = 19,
  parameter int MAX_DEGREE       = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [32:0] in_threshold,
  input  logic [31:0] in_jump_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_point,
  output logic        out_stream_bit
);

  localparam int AW = (MAX_POINT_WIDTH > 1) ? $clog2(MAX_POINT_WIDTH) : 1;
  localparam int CW = $clog2(MAX_POINT_WIDTH + 1);

  ssbg_pkg::state_t state_r, state_nxt;

  logic [5:0]  cfg_pw_r;
  logic [4:0]  cfg_dim_r;
  logic [2:0]  cfg_deg_r;
  logic [4:0]  cfg_coef_r;
  logic [20:0] cfg_init_r;

  logic [31:0] position_r, position_nxt;
  logic [31:0] point_r, point_nxt;
  logic [31:0] gray_r, gray_nxt;
  logic [CW-1:0] jcnt_r, jcnt_nxt;
  logic [CW-1:0] bld_r, bld_nxt;
  logic [ssbg_pkg::SEED_CNT-1:0][31:0] hist_r, hist_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_point_r, out_point_nxt;
  logic        out_bit_r, out_bit_nxt;

  logic [5:0]  w_eff;
  logic [4:0]  d_eff;
  logic [2:0]  s_eff;
  logic [31:0] pmask;
  ssbg_pkg::row_t row;
  logic        dim_one;

  logic [31:0] hs, rec, m_val, ram_wdata, ram_rdata, jpos;
  logic [AW-1:0] ram_addr;
  logic        ram_we;
  logic        cfg_hit, in_acc, adv, jmp, wrap;

  // ---------------- configuration decode ----------------
  assign cfg_hit = cfg_we && (cfg_index <= ssbg_pkg::CFG_CUSTOM_INIT);

  always_comb begin
    if (cfg_pw_r == 6'd0) w_eff = 6'd1;
    else if (cfg_pw_r > 6'(MAX_POINT_WIDTH)) w_eff = 6'(MAX_POINT_WIDTH);
    else w_eff = cfg_pw_r;

    if (cfg_dim_r > 5'(TABLE_DIMENSIONS)) d_eff = 5'(TABLE_DIMENSIONS);
    else d_eff = cfg_dim_r;

    if (cfg_deg_r == 3'd0) s_eff = 3'd1;
    else if (cfg_deg_r > 3'(MAX_DEGREE)) s_eff = 3'(MAX_DEGREE);
    else s_eff = cfg_deg_r;

    pmask   = 32'hFFFF_FFFF >> (6'd32 - w_eff);
    dim_one = (d_eff == 5'd1);
    if (d_eff >= 5'd2) begin
      row = ssbg_pkg::row_lookup(d_eff - 5'd2);
    end else begin
      row.deg  = s_eff;
      row.coef = cfg_coef_r;
      row.seed = ssbg_pkg::unpack_seeds(cfg_init_r);
    end
  end

  // ---------------- direction number recurrence ----------------
  always_comb begin
    hs  = hist_r[3'(row.deg - 3'd1)];
    rec = hs ^ (hs << row.deg);
    for (int k = 1; k < ssbg_pkg::SEED_CNT; k++) begin
      if (k < int'(row.deg) && row.coef[3'(int'(row.deg) - 1 - k)]) begin
        rec = rec ^ (hist_r[k-1] << k);
      end
    end
    if (dim_one) m_val = 32'd1;
    else if (6'(bld_r) <= {3'd0, row.deg}) m_val = 32'(row.seed[3'(bld_r - CW'(1))]);
    else m_val = rec;
    ram_wdata = m_val << (w_eff - 6'(bld_r));
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssbg_pkg::ST_BUILD:  if (6'(bld_r) == w_eff) state_nxt = ssbg_pkg::ST_SETTLE;
      ssbg_pkg::ST_SETTLE: state_nxt = ssbg_pkg::ST_RUN;
      ssbg_pkg::ST_RUN:    if (in_acc && in_action) state_nxt = ssbg_pkg::ST_JUMP;
      ssbg_pkg::ST_JUMP:   if (6'(jcnt_r) == w_eff) state_nxt = ssbg_pkg::ST_RUN;
      default:             state_nxt = ssbg_pkg::ST_BUILD;
    endcase
    if (cfg_hit) state_nxt = ssbg_pkg::ST_BUILD;
  end

  // ---------------- FSM outputs ----------------
  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    unique case (state_r)
      ssbg_pkg::ST_BUILD:  ram_we = 1'b1;
      ssbg_pkg::ST_RUN:    in_stall = out_valid_r && out_stall;
      ssbg_pkg::ST_SETTLE,
      ssbg_pkg::ST_JUMP:   in_stall = 1'b1;
      default:             in_stall = 1'b1;
    endcase
  end

  assign in_acc = in_valid && !in_stall;
  assign adv    = in_acc && !in_action;
  assign jmp    = in_acc && in_action;
  assign wrap   = (position_r == pmask);
  assign jpos   = in_jump_index & pmask;

  // ---------------- datapath ----------------
  always_comb begin
    position_nxt  = position_r;
    point_nxt     = point_r;
    gray_nxt      = gray_r;
    jcnt_nxt      = jcnt_r;
    bld_nxt       = bld_r;
    hist_nxt      = hist_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_point_nxt = out_point_r;
    out_bit_nxt   = out_bit_r;

    unique case (state_r)
      ssbg_pkg::ST_BUILD: begin
        hist_nxt = {hist_r[ssbg_pkg::SEED_CNT-2:0], m_val};
        bld_nxt  = bld_r + CW'(1);
      end
      ssbg_pkg::ST_RUN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_point_nxt = point_r;
          out_bit_nxt   = in_threshold > {1'b0, point_r};
          if (wrap) begin
            position_nxt = 32'd0;
            point_nxt    = 32'd0;
          end else begin
            position_nxt = position_r + 32'd1;
            point_nxt    = point_r ^ ram_rdata;
          end
        end else if (jmp) begin
          position_nxt = jpos;
          gray_nxt     = jpos ^ (jpos >> 1);
          point_nxt    = 32'd0;
          jcnt_nxt     = '0;
        end
      end
      ssbg_pkg::ST_JUMP: begin
        jcnt_nxt = jcnt_r + CW'(1);
        if (jcnt_r != '0) begin
          if (gray_r[0]) point_nxt = point_r ^ ram_rdata;
          gray_nxt = gray_r >> 1;
        end
      end
      default: begin
      end
    endcase

    if (cfg_hit) begin
      position_nxt = 32'd0;
      point_nxt    = 32'd0;
      bld_nxt      = CW'(1);
    end

    // write address in build, jump counter in jump; otherwise prefetch the vector the next advance needs
    if (state_r == ssbg_pkg::ST_BUILD) ram_addr = AW'(bld_r - CW'(1));
    else if (state_r == ssbg_pkg::ST_JUMP && 6'(jcnt_r) < w_eff) ram_addr = AW'(jcnt_r);
    else ram_addr = AW'(ssbg_pkg::lowest_zero(position_nxt));
  end

  ssbg_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINT_WIDTH)
  ) u_dv_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssbg_pkg::ST_BUILD;
      cfg_pw_r    <= ssbg_pkg::RST_POINT_WIDTH;
      cfg_dim_r   <= ssbg_pkg::RST_DIMENSION;
      cfg_deg_r   <= ssbg_pkg::RST_CUSTOM_DEGREE;
      cfg_coef_r  <= ssbg_pkg::RST_CUSTOM_COEFFS;
      cfg_init_r  <= ssbg_pkg::RST_CUSTOM_INIT;
      position_r  <= 32'd0;
      point_r     <= 32'd0;
      jcnt_r      <= '0;
      bld_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      position_r  <= position_nxt;
      point_r     <= point_nxt;
      jcnt_r      <= jcnt_nxt;
      bld_r       <= bld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ssbg_pkg::CFG_POINT_WIDTH:   cfg_pw_r   <= cfg_wdata[5:0];
          ssbg_pkg::CFG_DIMENSION:     cfg_dim_r  <= cfg_wdata[4:0];
          ssbg_pkg::CFG_CUSTOM_DEGREE: cfg_deg_r  <= cfg_wdata[2:0];
          ssbg_pkg::CFG_CUSTOM_COEFFS: cfg_coef_r <= cfg_wdata[4:0];
          ssbg_pkg::CFG_CUSTOM_INIT:   cfg_init_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    gray_r      <= gray_nxt;
    hist_r      <= hist_nxt;
    out_point_r <= out_point_nxt;
    out_bit_r   <= out_bit_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_point      = out_point_r;
  assign out_stream_bit = out_bit_r;

  // ---------------- assertions ----------------
  a_pos_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ssbg_pkg::ST_RUN |-> (position_r & ~pmask) == 32'd0)
    else $error("position outside period");

  a_wrap_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && wrap) |=> (position_r == 32'd0 && point_r == 32'd0))
    else $error("sequence did not restart at period end");

  a_jump_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (jmp && !(out_valid_r && out_stall)) |=> !out_valid_r)
    else $error("jump produced a result");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssbg_pkg::ST_BUILD || state_r == ssbg_pkg::ST_JUMP) |-> in_stall)
    else $error("item taken during rebuild or jump");

endmodule
